// File: rtl/rdr_pkg.sv
// Shared types, constants and codes for the radix divide and reformat block.
package rdr_pkg;

    localparam int DIGIT_W    = 7;
    localparam int RADIX_W    = 7;
    localparam int DIV_W      = 63;
    localparam int WIDTH_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIV_W;
    localparam int BUF_AW     = 6;
    localparam int REM_W      = DIV_W + 1;

    localparam int MAX_OUT_DIGITS_DEF = 64;
    localparam int VALUE_BITS_DEF     = 64;

    localparam logic [RADIX_W-1:0] RADIX_RST     = 7'd10;
    localparam logic [DIV_W-1:0]   DIVISOR_RST   = 63'd1;
    localparam logic [WIDTH_W-1:0] OUT_WIDTH_RST = 7'd8;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH = 2'd2;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_in;
        logic               digit_last;
    } in_item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_out;
        logic               out_last;
        logic               overflowed;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Digit buffer write port
    typedef struct packed {
        logic               en;
        logic [BUF_AW-1:0]  addr;
        logic [DIGIT_W-1:0] data;
    } buf_wr_t;

    // Start of one readout burst
    typedef struct packed {
        logic               go;
        logic [WIDTH_W-1:0] count;
        logic               ovf;
    } emit_cmd_t;

endpackage

// File: rtl/radix_divide_and_reformat.sv
// Top level: serial radix accumulate, divide by divisor, reformat into quotient digits.
//
//  channel   | handshake            | payload              | direction
//  ----------+----------------------+----------------------+----------
//  input     | start / busy         | item   (in_item_t)   | in
//  result    | strobe (one cycle)   | result (out_item_t)  | out
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data  | in
//
// Flow: a digit not marked last is accepted, then folded in by 7 shift-add
// steps over the radix bits. A last digit adds a restoring division, then per
// quotient digit a serial division by the radix (skipped once the remaining
// quotient is zero), then a drain of the digit buffer through the readout.
// Reset clears control state and the accumulator at once; no clearing pass.
// start is ignored while busy; the receiver cannot stall the result strobe.
module radix_divide_and_reformat #(
    parameter int MAX_OUT_DIGITS = rdr_pkg::MAX_OUT_DIGITS_DEF,
    parameter int VALUE_BITS     = rdr_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  rdr_pkg::in_item_t              item,
    output logic                           strobe,
    output rdr_pkg::out_item_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rdr_pkg::*;

    localparam int AW     = (MAX_OUT_DIGITS > 1) ? $clog2(MAX_OUT_DIGITS) : 1;
    localparam int PROD_W = VALUE_BITS + RADIX_W;
    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int MUL_W  = $clog2(RADIX_W);

    // Control and configuration state
    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [DIV_W-1:0]   divisor_reg, divisor_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic               ovf_reg, ovf_next;
    logic [MUL_W-1:0]   mul_cnt_reg, mul_cnt_next;
    logic [BIT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;

    // Datapath registers
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               last_reg, last_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [RADIX_W-1:0] drem_reg, drem_next;

    logic [RADIX_W-1:0] r_eff;
    logic [DIV_W-1:0]   div_eff;
    logic [WIDTH_W-1:0] w_eff;

    logic [PROD_W-1:0]  prod_step;
    logic [REM_W-1:0]   div_shift, div_ext, div_rem;
    logic               div_ge;
    logic [RADIX_W:0]   cv_shift, cv_ext, cv_diff;
    logic [RADIX_W-1:0] cv_rem;
    logic               cv_ge;

    buf_wr_t   wr;
    emit_cmd_t cmd;
    logic      emit_pending;

    // Substitute legal values for out-of-range settings
    assign r_eff   = (radix_reg < RADIX_W'(2)) ? RADIX_W'(2) : radix_reg;
    assign div_eff = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
    assign w_eff   = (width_reg == '0) ? WIDTH_W'(1) :
                     (width_reg > WIDTH_W'(MAX_OUT_DIGITS)) ? WIDTH_W'(MAX_OUT_DIGITS) :
                     width_reg;

    // One shift-add step of value * radix, radix bits taken MSB first;
    // the incoming digit joins on the final step
    assign prod_step = {prod_reg[PROD_W-2:0], 1'b0}
                     + (r_eff[mul_cnt_reg] ? PROD_W'(value_reg) : PROD_W'(0))
                     + ((mul_cnt_reg == '0) ? PROD_W'(digit_reg) : PROD_W'(0));

    // One restoring step of value / divisor; the remainder stays below 2^63
    assign div_shift = {rem_reg[REM_W-2:0], value_reg[VALUE_BITS-1]};
    assign div_ext   = {1'b0, div_eff};
    assign div_ge    = div_shift >= div_ext;
    assign div_rem   = div_ge ? (div_shift - div_ext) : div_shift;

    // One restoring step of quotient / radix on a narrow remainder
    assign cv_shift = {drem_reg, value_reg[VALUE_BITS-1]};
    assign cv_ext   = {1'b0, r_eff};
    assign cv_ge    = cv_shift >= cv_ext;
    assign cv_diff  = cv_shift - cv_ext;
    assign cv_rem   = cv_ge ? cv_diff[RADIX_W-1:0] : cv_shift[RADIX_W-1:0];

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;

    always_comb
    begin
        logic               digit_done;
        logic [RADIX_W-1:0] digit_val;

        state_next   = state_reg;
        radix_next   = radix_reg;
        divisor_next = divisor_reg;
        width_next   = width_reg;
        value_next   = value_reg;
        ovf_next     = ovf_reg;
        mul_cnt_next = mul_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        wr_addr_next = wr_addr_reg;
        digit_next   = digit_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        drem_next    = drem_reg;
        wr           = '0;
        cmd          = '0;
        digit_done   = 1'b0;
        digit_val    = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RADIX:     radix_next   = cfg_data[RADIX_W-1:0];
                CFG_DIVISOR:   divisor_next = cfg_data[DIV_W-1:0];
                CFG_OUT_WIDTH: width_next   = cfg_data[WIDTH_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    digit_next   = item.digit_in;
                    last_next    = item.digit_last;
                    prod_next    = '0;
                    mul_cnt_next = MUL_W'(RADIX_W - 1);
                    state_next   = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next = prod_step;
                if (mul_cnt_reg == '0)
                begin
                    // keep the low bits, flag anything above them as a wrap
                    value_next = prod_step[VALUE_BITS-1:0];
                    ovf_next   = ovf_reg | (|prod_step[PROD_W-1:VALUE_BITS]);
                    if (last_reg)
                    begin
                        bit_cnt_next = BIT_W'(VALUE_BITS - 1);
                        rem_next     = '0;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mul_cnt_next = mul_cnt_reg - MUL_W'(1);
                end
            end

            ST_DIV:
            begin
                // quotient bits shift in where dividend bits shift out
                rem_next   = div_rem;
                value_next = {value_reg[VALUE_BITS-2:0], div_ge};
                if (bit_cnt_reg == '0)
                begin
                    bit_cnt_next = BIT_W'(VALUE_BITS - 1);
                    drem_next    = '0;
                    wr_addr_next = AW'(w_eff - WIDTH_W'(1));
                    state_next   = ST_CONV;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                end
            end

            ST_CONV:
            begin
                if ((bit_cnt_reg == BIT_W'(VALUE_BITS - 1)) && (value_reg == '0))
                begin
                    // nothing left of the quotient: this digit and all above are zero
                    digit_done = 1'b1;
                    digit_val  = '0;
                end
                else
                begin
                    drem_next  = cv_rem;
                    value_next = {value_reg[VALUE_BITS-2:0], cv_ge};
                    if (bit_cnt_reg == '0)
                    begin
                        digit_done = 1'b1;
                        digit_val  = cv_rem;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                    end
                end

                if (digit_done)
                begin
                    // store digits least significant first, from the top address down
                    wr.en        = 1'b1;
                    wr.addr      = BUF_AW'(wr_addr_reg);
                    wr.data      = digit_val;
                    drem_next    = '0;
                    bit_cnt_next = BIT_W'(VALUE_BITS - 1);
                    if (wr_addr_reg == '0)
                    begin
                        cmd.go     = 1'b1;
                        cmd.count  = w_eff;
                        cmd.ovf    = ovf_reg;
                        ovf_next   = 1'b0;
                        value_next = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        wr_addr_next = wr_addr_reg - AW'(1);
                    end
                end
            end

            ST_EMIT:
            begin
                if (!emit_pending)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_RST;
            divisor_reg <= DIVISOR_RST;
            width_reg   <= OUT_WIDTH_RST;
            value_reg   <= '0;
            ovf_reg     <= 1'b0;
            mul_cnt_reg <= '0;
            bit_cnt_reg <= '0;
            wr_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            radix_reg   <= radix_next;
            divisor_reg <= divisor_next;
            width_reg   <= width_next;
            value_reg   <= value_next;
            ovf_reg     <= ovf_next;
            mul_cnt_reg <= mul_cnt_next;
            bit_cnt_reg <= bit_cnt_next;
            wr_addr_reg <= wr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        last_reg  <= last_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        drem_reg  <= drem_next;
    end

    rdr_outbuf #(
        .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
    ) u_outbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .cmd     (cmd),
        .strobe  (strobe),
        .result  (result),
        .pending (emit_pending)
    );

    // Results leave only during the readout burst
    a_strobe_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (state_reg == ST_EMIT))
        else $error("result strobe outside readout");

    // The next number starts from a clean accumulator and overflow flag
    a_clean_after_number: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((value_reg == '0) && !ovf_reg))
        else $error("accumulator not cleared after number");

    // Nothing follows the final digit of a quotient
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.out_last) |=> !strobe)
        else $error("result after final digit");

    // An accepted transaction always enters the multiply-add
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_MUL))
        else $error("accepted digit not processed");

endmodule

// File: rtl/rdr_outbuf.sv
// Quotient digit buffer and most-significant-first readout sequencer.
module rdr_outbuf #(
    parameter int MAX_OUT_DIGITS = rdr_pkg::MAX_OUT_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rdr_pkg::buf_wr_t   wr,
    input  rdr_pkg::emit_cmd_t cmd,
    output logic               strobe,
    output rdr_pkg::out_item_t result,
    output logic               pending
);
    import rdr_pkg::*;

    localparam int AW    = (MAX_OUT_DIGITS > 1) ? $clog2(MAX_OUT_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_OUT_DIGITS + 1);

    logic [DIGIT_W-1:0] mem [MAX_OUT_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic             active_reg, active_next;
    logic             strobe_reg, strobe_next;
    logic             last_reg, last_next;
    logic             ovf_reg, ovf_next;
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0] left_reg, left_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (active_reg)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_comb
    begin
        active_next  = active_reg;
        rd_addr_next = rd_addr_reg;
        left_next    = left_reg;
        ovf_next     = ovf_reg;
        strobe_next  = active_reg;
        last_next    = active_reg && (left_reg == CNT_W'(1));
        if (cmd.go)
        begin
            active_next  = 1'b1;
            rd_addr_next = '0;
            left_next    = cmd.count[CNT_W-1:0];
            ovf_next     = cmd.ovf;
        end
        else if (active_reg)
        begin
            // advance one digit per cycle, drop out after the final one
            rd_addr_next = rd_addr_reg + AW'(1);
            left_next    = left_reg - CNT_W'(1);
            if (left_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        left_reg    <= left_next;
        last_reg    <= last_next;
        ovf_reg     <= ovf_next;
    end

    assign strobe  = strobe_reg;
    assign pending = active_reg || strobe_reg;
    assign result  = '{digit_out: rd_data_reg, out_last: last_reg, overflowed: ovf_reg};

endmodule

// File: verif/radix_divide_and_reformat_tb.sv
// Self-checking testbench for the radix divide and reformat block.
`timescale 1ns / 100ps

module radix_divide_and_reformat_tb;

    import rdr_pkg::*;

    // Silent stretch, in cycles, that ends the run as hung.
    localparam int STALL_LIMIT   = 20000;
    // Pause after the final result before a register write and at the end;
    // covers a trailing digit that is still being accumulated.
    localparam int SETTLE_CYCLES = 24;
    localparam int ITEMS_PER_SET = 30;

    // Index past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    in_item_t              item      = '0;
    logic                  strobe;
    out_item_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    radix_divide_and_reformat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Digits waiting to be driven, and quotient digits the block still owes
    in_item_t  pending_digits[$];
    out_item_t quotient_digits_q[$];

    int items_queued     = 0;
    int items_accepted   = 0;
    int sender_idle_pct  = 9;
    int error_count      = 0;
    int silent_cycles    = 0;
    logic item_taken     = 1'b0;

    // Shadow of the block: configuration registers and accumulation state
    logic [RADIX_W-1:0] radix_reg   = RADIX_RST;
    logic [DIV_W-1:0]   divisor_reg = DIVISOR_RST;
    logic [WIDTH_W-1:0] width_reg   = OUT_WIDTH_RST;
    logic [63:0]        acc_value   = '0;
    logic               acc_wrapped = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Mirror one accepted register-write transaction; unknown indexes drop
    function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                                 logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_RADIX:     radix_reg   = data[RADIX_W-1:0];
            CFG_DIVISOR:   divisor_reg = data[DIV_W-1:0];
            CFG_OUT_WIDTH: width_reg   = data[WIDTH_W-1:0];
            default:       ;
        endcase
    endfunction

    // Fold one digit into the accumulator; on the last digit, divide and
    // queue the quotient digits the block must emit, most significant first.
    function automatic void accumulate_digit(in_item_t it);
        logic [63:0]        base;
        logic [63:0]        dval;
        logic [63:0]        dvsr;
        logic [63:0]        quot;
        int                 ndig;
        logic [DIGIT_W-1:0] digits [MAX_OUT_DIGITS_DEF];
        out_item_t          exp_digit;
        base = (radix_reg < 2) ? 64'd2 : 64'(radix_reg);
        dval = 64'(it.digit_in);
        // Flag a wrap before the multiply-add, exactly as the block must
        if (acc_value > (64'hFFFF_FFFF_FFFF_FFFF - dval) / base)
            acc_wrapped = 1'b1;
        acc_value = acc_value * base + dval;
        if (it.digit_last)
        begin
            dvsr = (divisor_reg == '0) ? 64'd1 : 64'(divisor_reg);
            quot = acc_value / dvsr;
            if (width_reg == 0)
                ndig = 1;
            else if (width_reg > MAX_OUT_DIGITS_DEF)
                ndig = MAX_OUT_DIGITS_DEF;
            else
                ndig = int'(width_reg);
            // Extract low digits first; high digits beyond ndig are cut off
            for (int i = 0; i < ndig; i++)
            begin
                digits[ndig - 1 - i] = DIGIT_W'(quot % base);
                quot = quot / base;
            end
            for (int i = 0; i < ndig; i++)
            begin
                exp_digit.digit_out  = digits[i];
                exp_digit.out_last   = (i == ndig - 1);
                exp_digit.overflowed = acc_wrapped;
                quotient_digits_q = {quotient_digits_q, exp_digit};
            end
            acc_value   = '0;
            acc_wrapped = 1'b0;
        end
    endfunction

    // Driver: advance to the next digit once the current transaction is taken,
    // hold start and item while the block is busy, idle at random otherwise.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || item_taken)
        begin
            if (pending_digits.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
            begin
                start <= 1'b1;
                item  <= pending_digits.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Input side: predict on every accepted digit and mirror register writes
    always @(posedge clk)
    begin
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= start && !busy;
            if (start && !busy)
            begin
                accumulate_digit(item);
                items_accepted <= items_accepted + 1;
            end
            if (cfg_valid && cfg_ready)
                apply_register_write(cfg_index, cfg_data);
        end
    end

    // Monitor: every strobed result must match the oldest owed quotient digit
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && strobe)
        begin
            if (quotient_digits_q.size() == 0)
                report_mismatch($sformatf("unexpected result digit %0d last %0b ovf %0b",
                                          result.digit_out, result.out_last,
                                          result.overflowed));
            else
            begin
                want = quotient_digits_q.pop_front();
                if (result.digit_out !== want.digit_out)
                    report_mismatch($sformatf("digit_out got %0d want %0d",
                                              result.digit_out, want.digit_out));
                if (result.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last got %0b want %0b",
                                              result.out_last, want.out_last));
                if (result.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed got %0b want %0b",
                                              result.overflowed, want.overflowed));
            end
        end
    end

    // Watchdog: any transaction on any channel resets the silence count
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
            silent_cycles <= 0;
        else
            silent_cycles <= silent_cycles + 1;
        if (silent_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_digit(input int value, input bit last);
        in_item_t it;
        it.digit_in   = DIGIT_W'(value);
        it.digit_last = last;
        pending_digits = {pending_digits, it};
        items_queued++;
    endtask

    // Hold until every digit is taken and every quotient digit has arrived,
    // then let a trailing digit finish before touching the registers.
    task automatic wait_idle();
        while (items_accepted != items_queued || quotient_digits_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Issue one write transaction; returns at the falling edge after it is taken
    // with valid still high, so back-to-back writes never drop valid.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input int rdx, input logic [DIV_W-1:0] dv, input int w,
                             input bit poke_unused);
        write_register(CFG_RADIX, CFG_DATA_W'(rdx));
        write_register(CFG_DIVISOR, dv);
        write_register(CFG_OUT_WIDTH, CFG_DATA_W'(w));
        if (poke_unused)
            write_register(CFG_UNUSED, CFG_DATA_W'({$urandom(), $urandom()}));
        cfg_valid <= 1'b0;
    endtask

    // One random setting followed by well-formed numbers with random digits;
    // a few digits are out of range and a dangling digit may carry over.
    task automatic random_phase();
        int               rdx;
        int               w;
        int               top_digit;
        int               len;
        int               count;
        logic [DIV_W-1:0] dv;
        case ($urandom_range(7, 0))
            0:       rdx = 2;
            1:       rdx = 10;
            2:       rdx = 16;
            3:       rdx = 100;
            4:       rdx = 127;
            5:       rdx = $urandom_range(1, 0);
            default: rdx = $urandom_range(127, 2);
        endcase
        case ($urandom_range(5, 0))
            0:       dv = DIV_W'(1);
            1:       dv = DIV_W'(0);
            2:       dv = {DIV_W{1'b1}};
            3:       dv = DIV_W'($urandom_range(1000, 2));
            default: dv = DIV_W'({$urandom(), $urandom()}) >> $urandom_range(62, 0);
        endcase
        case ($urandom_range(7, 0))
            0:       w = MAX_OUT_DIGITS_DEF;
            1:       w = 0;
            2:       w = $urandom_range(127, 65);
            default: w = $urandom_range(12, 1);
        endcase
        configure(rdx, dv, w, $urandom_range(3, 0) == 0);
        top_digit = (rdx < 2) ? 1 : rdx - 1;
        count = 0;
        while (count < ITEMS_PER_SET)
        begin
            // Long numbers can drive the accumulator past 64 bits
            len = ($urandom_range(5, 0) == 0) ? $urandom_range(30, 7) : $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(9, 0) == 0)
                    queue_digit($urandom_range(127, 0), k == len - 1);
                else
                    queue_digit($urandom_range(top_digit, 0), k == len - 1);
            end
            count += len;
        end
        if ($urandom_range(3, 0) == 0)
            queue_digit($urandom_range(127, 0), 1'b0);
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: zero, a digit at the field maximum and a digit
        // at or above the radix
        queue_digit(0, 1'b1);
        queue_digit(127, 1'b0);
        queue_digit(99, 1'b0);
        queue_digit(5, 1'b1);
        wait_idle();

        // Largest radix, zero divisor, zero width, write past the register
        // list; ten digits of 127 wrap the accumulator
        configure(127, '0, 0, 1'b1);
        for (int k = 0; k < 10; k++)
            queue_digit(127, k == 9);
        wait_idle();

        // Radix zero, largest divisor, width above the maximum
        configure(0, {DIV_W{1'b1}}, 127, 1'b0);
        queue_digit(127, 1'b0);
        queue_digit(127, 1'b0);
        queue_digit(127, 1'b1);
        wait_idle();

        // Radix one, full width of binary digits
        configure(1, DIV_W'(3), MAX_OUT_DIGITS_DEF, 1'b0);
        queue_digit(1, 1'b0);
        queue_digit(0, 1'b0);
        queue_digit(1, 1'b1);
        wait_idle();

        // Radix hundred, one-digit width cuts the quotient
        configure(100, DIV_W'(7), 1, 1'b0);
        queue_digit(99, 1'b0);
        queue_digit(99, 1'b1);
        wait_idle();

        // Random part: sender mostly busy, then mostly idle, then never idle
        for (int seg = 0; seg < 3; seg++)
        begin
            sender_idle_pct = (seg == 0) ? 9 : (seg == 1) ? 88 : 0;
            for (int p = 0; p < 3; p++)
                random_phase();
        end

        wait_idle();
        if (error_count == 0 && quotient_digits_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rdr_pkg.sv
rtl/rdr_outbuf.sv
rtl/radix_divide_and_reformat.sv
verif/radix_divide_and_reformat_tb.sv
